// File: rtl/core/best_fit_segment_allocator_macros.svh
// ---------------------------------------------------------------------------
// Best-fit segment allocator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

`define BFSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bfsa_pkg.sv
// ---------------------------------------------------------------------------
// Best-fit segment allocator package
// Default sizes, result error codes and request types.
// ---------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int OFFSET_BITS_DEF  = 20;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_NO_FIT      = 3'd1;
  localparam logic [2:0] ERR_TOO_SMALL   = 3'd2;
  localparam logic [2:0] ERR_BAD_RELEASE = 3'd3;
  localparam logic [2:0] ERR_TABLE_FULL  = 3'd4;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/best_fit_segment_allocator.sv
// ---------------------------------------------------------------------------
// Best-fit segment allocator
// Segment table in a single-port-read memory with scan, shift and write-back.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be stalled. Each request
// reads the table one entry per cycle through the memory read port. A request
// that fails is answered after the scan, and one that succeeds first shifts the
// table when a split or merge moves entries, writes the split-off entry for a
// split, and then writes the updated entry. The result appears in the first
// cycle with busy low. After reset or a write of arena_bytes the block is busy
// while it writes the first table entry.
`default_nettype none

module best_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF,
  parameter int HEADER_BYTES = bfsa_pkg::HEADER_BYTES_DEF,
  parameter int OFFSET_BITS  = bfsa_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [OFFSET_BITS:0]   arena_bytes,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   req_type,
  input  wire logic [OFFSET_BITS-1:0] alloc_bytes,
  input  wire logic [OFFSET_BITS-1:0] release_offset,
  output logic                        done,
  output logic                        granted,
  output logic [OFFSET_BITS-1:0]      payload_offset,
  output logic [2:0]                  error_code
);

  localparam int OB = OFFSET_BITS;
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = AW + 1;
  localparam logic [OB:0] HDR   = (OB+1)'(HEADER_BYTES);
  localparam logic [OB:0] LIMIT = (OB+1)'(1) << OB;
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  typedef struct packed {
    logic [OB-1:0] seg_start;
    logic [OB-1:0] seg_size;
    logic          seg_free;
  } entry_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_WR2, S_WR1
  } state_t;

  state_t state;
  entry_t mem [MAX_SEGMENTS];
  entry_t rd_data;

  logic [OB:0]    arena;
  logic           too_small;
  logic [CW-1:0]  count;
  logic           req;
  logic [OB-1:0]  want;
  logic [OB-1:0]  offset;
  logic [CW-1:0]  k;
  logic           pv;
  logic [CW-1:0]  pidx;
  logic           found;
  logic [CW-1:0]  pick;
  entry_t         best;
  entry_t         prev;
  entry_t         next;
  logic           have_next;
  logic           up;
  logic [1:0]     drop;
  logic [CW-1:0]  ra;
  logic [CW-1:0]  n;
  logic [CW-1:0]  pend_dst;
  logic [AW-1:0]  fin_addr;
  entry_t         fin_data;
  logic [AW-1:0]  sec_addr;
  entry_t         sec_data;
  logic           split_pending;

  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           we;
  logic [AW-1:0]  wa;
  entry_t         wd;
  logic [OB:0]    arena_clamped;
  logic [OB:0]    need;
  logic           mp;
  logic           mn;
  logic [OB:0]    match_off;

  assign busy = (state != S_IDLE);
  assign arena_clamped = (arena > LIMIT) ? LIMIT : arena;
  assign need = {1'b0, want} + HDR;
  assign mp = found && (pidx != '0) && prev.seg_free && (pick != '0);
  assign mn = have_next && next.seg_free;
  assign match_off = {1'b0, rd_data.seg_start} + HDR;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = k[AW-1:0];
    we      = 1'b0;
    wa      = fin_addr;
    wd      = fin_data;
    unique case (state)
      S_SCAN: begin
        rd_en   = (k < count);
        rd_addr = k[AW-1:0];
      end
      S_SHIFT: begin
        rd_en   = (n != '0);
        rd_addr = ra[AW-1:0];
        we      = pv;
        wa      = pend_dst[AW-1:0];
        wd      = rd_data;
      end
      S_WR2: begin
        we = 1'b1;
        wa = sec_addr;
        wd = sec_data;
      end
      S_WR1: begin
        we = 1'b1;
      end
      S_INIT: begin
        we = 1'b1;
        wa = '0;
        wd.seg_start = '0;
        wd.seg_size  = (arena_clamped < HDR) ? '0 : OB'(arena_clamped - HDR);
        wd.seg_free  = !(arena_clamped < HDR);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      arena     <= LIMIT;
      done      <= 1'b0;
      pv        <= 1'b0;
      count     <= CW'(1);
      too_small <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        arena <= arena_bytes;
        state <= S_INIT;
      end else begin
        unique case (state)
          S_INIT: begin
            too_small <= (arena_clamped < HDR);
            count     <= CW'(1);
            state     <= S_IDLE;
          end
          S_IDLE: begin
            if (start) begin
              req       <= req_type;
              want      <= alloc_bytes;
              offset    <= release_offset;
              k         <= '0;
              pv        <= 1'b0;
              found     <= 1'b0;
              have_next <= 1'b0;
              pick      <= '0;
              state     <= S_SCAN;
            end
          end
          S_SCAN: begin
            pv   <= (k < count);
            pidx <= k;
            if (k < count) begin
              k <= k + CW'(1);
            end
            if (pv) begin
              if (req == bfsa_pkg::REQ_ALLOC) begin
                if (rd_data.seg_free && rd_data.seg_size >= want &&
                    (!found || best.seg_size > rd_data.seg_size)) begin
                  found <= 1'b1;
                  pick  <= pidx;
                  best  <= rd_data;
                end
              end else if (!found) begin
                if (!rd_data.seg_free && match_off == {1'b0, offset}) begin
                  found <= 1'b1;
                  pick  <= pidx;
                  best  <= rd_data;
                end else begin
                  prev <= rd_data;
                end
              end else if (pidx == pick + CW'(1)) begin
                next      <= rd_data;
                have_next <= 1'b1;
              end
            end
            if (!(k < count) && !pv) begin
              state <= S_DECIDE;
            end
          end
          S_DECIDE: begin
            granted        <= 1'b0;
            payload_offset <= '0;
            error_code     <= bfsa_pkg::ERR_NONE;
            pv             <= 1'b0;
            if (too_small) begin
              error_code <= bfsa_pkg::ERR_TOO_SMALL;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else if (req == bfsa_pkg::REQ_ALLOC) begin
              if (!found) begin
                error_code <= bfsa_pkg::ERR_NO_FIT;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else if ({1'b0, best.seg_size} > need) begin
                if (count >= MAXC) begin
                  error_code <= bfsa_pkg::ERR_TABLE_FULL;
                  done       <= 1'b1;
                  state      <= S_IDLE;
                end else begin
                  up                 <= 1'b1;
                  ra                 <= count - CW'(1);
                  n                  <= count - CW'(1) - pick;
                  count              <= count + CW'(1);
                  sec_addr           <= AW'(pick + CW'(1));
                  sec_data.seg_start <= OB'({1'b0, best.seg_start} + need);
                  sec_data.seg_size  <= OB'({1'b0, best.seg_size} - need);
                  sec_data.seg_free  <= 1'b1;
                  fin_addr           <= pick[AW-1:0];
                  fin_data.seg_start <= best.seg_start;
                  fin_data.seg_size  <= want;
                  fin_data.seg_free  <= 1'b0;
                  split_pending      <= 1'b1;
                  state              <= S_SHIFT;
                end
              end else begin
                fin_addr           <= pick[AW-1:0];
                fin_data.seg_start <= best.seg_start;
                fin_data.seg_size  <= best.seg_size;
                fin_data.seg_free  <= 1'b0;
                n                  <= '0;
                split_pending      <= 1'b0;
                state              <= S_SHIFT;
              end
            end else begin
              if (!found) begin
                error_code <= bfsa_pkg::ERR_BAD_RELEASE;
                done       <= 1'b1;
                state      <= S_IDLE;
              end else begin
                up    <= 1'b0;
                drop  <= {1'b0, mp} + {1'b0, mn};
                ra    <= pick + CW'(1) + CW'(mn);
                n     <= count - (pick + CW'(1) + CW'(mn));
                count <= count - CW'({1'b0, mp} + {1'b0, mn});
                fin_addr <= mp ? AW'(pick - CW'(1)) : pick[AW-1:0];
                fin_data.seg_start <= mp ? prev.seg_start : best.seg_start;
                fin_data.seg_size  <= OB'((mp ? {1'b0, prev.seg_size} : {1'b0, best.seg_size})
                  + (mp ? ({1'b0, best.seg_size} + HDR) : '0)
                  + (mn ? ({1'b0, next.seg_size} + HDR) : '0));
                fin_data.seg_free  <= 1'b1;
                split_pending      <= 1'b0;
                state              <= S_SHIFT;
              end
            end
          end
          S_SHIFT: begin
            pv <= (n != '0);
            if (n != '0) begin
              pend_dst <= up ? (ra + CW'(1)) : (ra - CW'(drop));
              ra       <= up ? (ra - CW'(1)) : (ra + CW'(1));
              n        <= n - CW'(1);
            end else if (!pv) begin
              state <= split_pending ? S_WR2 : S_WR1;
            end
          end
          S_WR2: begin
            state <= S_WR1;
          end
          S_WR1: begin
            granted        <= 1'b1;
            payload_offset <= (req == bfsa_pkg::REQ_ALLOC) ? OB'({1'b0, best.seg_start} + HDR)
                                                           : '0;
            error_code     <= bfsa_pkg::ERR_NONE;
            done           <= 1'b1;
            state          <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bfsa_checker.sv
// ---------------------------------------------------------------------------
// Best-fit segment allocator port checker
// Checks result consistency and request handshake behavior at the ports.
// ---------------------------------------------------------------------------
`default_nettype none
`include "best_fit_segment_allocator_macros.svh"

module bfsa_checker #(
  parameter int OFFSET_BITS = bfsa_pkg::OFFSET_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   cfg_we,
  input wire logic [OFFSET_BITS:0]   arena_bytes,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   req_type,
  input wire logic [OFFSET_BITS-1:0] alloc_bytes,
  input wire logic [OFFSET_BITS-1:0] release_offset,
  input wire logic                   done,
  input wire logic                   granted,
  input wire logic [OFFSET_BITS-1:0] payload_offset,
  input wire logic [2:0]             error_code
);

  `BFSA_ASSERT_NOW(a_grant_code, done, granted == (error_code == bfsa_pkg::ERR_NONE), "grant and error code disagree")
  `BFSA_ASSERT_NOW(a_fail_offset, done && !granted, payload_offset == '0, "failed result carries an offset")
  `BFSA_ASSERT_NEXT(a_accept_busy, start && !busy && !cfg_we, busy, "accepted transaction did not raise busy")
  `BFSA_ASSERT_NEXT(a_cfg_busy, cfg_we, busy && !done, "table rebuild not signaled as busy")

endmodule

bind best_fit_segment_allocator bfsa_checker #(.OFFSET_BITS(OFFSET_BITS)) u_bfsa_checker (.*);

`default_nettype wire

// File: dv/best_fit_segment_allocator_checker.sv
// ---------------------------------------------------------------------------
// Best-fit segment allocator checker
// Watches the configuration, request and result ports, keeps its own copy of
// the segment table to predict each result, and compares every transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module best_fit_segment_allocator_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [20:0] arena_bytes,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        req_type,
  input  wire logic [19:0] alloc_bytes,
  input  wire logic [19:0] release_offset,
  input  wire logic        done,
  input  wire logic        granted,
  input  wire logic [19:0] payload_offset,
  input  wire logic [2:0]  error_code,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGS = bfsa_pkg::MAX_SEGMENTS_DEF;
  localparam int HDR  = bfsa_pkg::HEADER_BYTES_DEF;

  typedef logic [21:0] span_t;
  typedef struct packed {
    logic        granted;
    logic [19:0] offset;
    logic [2:0]  err;
  } outcome_t;

  span_t    seg_base [SEGS];
  span_t    seg_len  [SEGS];
  bit       seg_free [SEGS];
  int       seg_count;
  bit       too_small;
  outcome_t awaited_q[$];

  assign pending = awaited_q.size();

  function automatic void rebuild_arena(logic [20:0] value);
    span_t arena;
    arena = (value > 21'h100000) ? span_t'(21'h100000) : span_t'(value);
    for (int k = 0; k < SEGS; k++) begin
      seg_base[k] = '0;
      seg_len[k]  = '0;
      seg_free[k] = 1'b0;
    end
    seg_count = 1;
    too_small = arena < HDR;
    if (!too_small) begin
      seg_len[0]  = arena - HDR;
      seg_free[0] = 1'b1;
    end
  endfunction

  function automatic void remove_segment(int idx);
    for (int k = idx; k + 1 < seg_count && k + 1 < SEGS; k++) begin
      seg_base[k] = seg_base[k + 1];
      seg_len[k]  = seg_len[k + 1];
      seg_free[k] = seg_free[k + 1];
    end
    if (seg_count > 0) begin
      seg_count--;
      seg_base[seg_count] = '0;
      seg_len[seg_count]  = '0;
      seg_free[seg_count] = 1'b0;
    end
  endfunction

  function automatic outcome_t allocate_segment(span_t want);
    outcome_t res;
    int       pick;
    bit       found;
    res   = '{granted: 1'b0, offset: '0, err: bfsa_pkg::ERR_NONE};
    pick  = 0;
    found = 1'b0;
    for (int k = 0; k < seg_count && k < SEGS; k++) begin
      if (seg_free[k] && seg_len[k] >= want && (!found || seg_len[pick] > seg_len[k])) begin
        pick  = k;
        found = 1'b1;
      end
    end
    if (!found) begin
      res.err = bfsa_pkg::ERR_NO_FIT;
      return res;
    end
    if (seg_len[pick] > want + HDR) begin
      if (seg_count >= SEGS) begin
        res.err = bfsa_pkg::ERR_TABLE_FULL;
        return res;
      end
      for (int k = seg_count; k > pick + 1; k--) begin
        seg_base[k] = seg_base[k - 1];
        seg_len[k]  = seg_len[k - 1];
        seg_free[k] = seg_free[k - 1];
      end
      seg_count++;
      seg_base[pick + 1] = seg_base[pick] + HDR + want;
      seg_len[pick + 1]  = seg_len[pick] - want - HDR;
      seg_free[pick + 1] = 1'b1;
      seg_len[pick]      = want;
    end
    seg_free[pick] = 1'b0;
    res.granted    = 1'b1;
    res.offset     = 20'(seg_base[pick] + HDR);
    return res;
  endfunction

  function automatic outcome_t release_segment(span_t offset);
    outcome_t res;
    int       cur;
    bit       found;
    res   = '{granted: 1'b0, offset: '0, err: bfsa_pkg::ERR_NONE};
    cur   = 0;
    found = 1'b0;
    for (int k = 0; k < seg_count && k < SEGS; k++) begin
      if (!found && !seg_free[k] && seg_base[k] + HDR == offset) begin
        cur   = k;
        found = 1'b1;
      end
    end
    if (!found) begin
      res.err = bfsa_pkg::ERR_BAD_RELEASE;
      return res;
    end
    if (cur > 0 && seg_free[cur - 1]) begin
      seg_len[cur - 1] += seg_len[cur] + HDR;
      remove_segment(cur);
      cur--;
    end
    if (cur + 1 < seg_count && seg_free[cur + 1]) begin
      seg_len[cur] += seg_len[cur + 1] + HDR;
      remove_segment(cur + 1);
    end
    seg_free[cur] = 1'b1;
    res.granted   = 1'b1;
    return res;
  endfunction

  function automatic outcome_t predict_request(logic rt, logic [19:0] want, logic [19:0] off);
    outcome_t res;
    res = '{granted: 1'b0, offset: '0, err: bfsa_pkg::ERR_TOO_SMALL};
    if (too_small) return res;
    if (rt == bfsa_pkg::REQ_ALLOC) return allocate_segment(span_t'(want));
    return release_segment(span_t'(off));
  endfunction

  always @(posedge clk) begin
    outcome_t exp_res;
    if (rst) begin
      fail_count = 0;
      rebuild_arena(21'h100000);
      awaited_q.delete();
    end else begin
      if (done) begin
        if (awaited_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction granted=%0b offset=%0d error=%0d",
                   $time, granted, payload_offset, error_code);
        end else begin
          exp_res = awaited_q.pop_front();
          if (granted !== exp_res.granted) begin
            fail_count++;
            $display("%0t: granted expected %0b actual %0b", $time, exp_res.granted, granted);
          end
          if (payload_offset !== exp_res.offset) begin
            fail_count++;
            $display("%0t: payload_offset expected %0d actual %0d",
                     $time, exp_res.offset, payload_offset);
          end
          if (error_code !== exp_res.err) begin
            fail_count++;
            $display("%0t: error_code expected %0d actual %0d", $time, exp_res.err, error_code);
          end
        end
      end
      if (cfg_we) rebuild_arena(arena_bytes);
      if (start && !busy)
        awaited_q.push_back(predict_request(req_type, alloc_bytes, release_offset));
    end
  end

endmodule

`default_nettype wire

// File: dv/best_fit_segment_allocator_test.sv
// ---------------------------------------------------------------------------
// Best-fit segment allocator testbench
// Drives directed and random allocate and release requests over several arena
// sizes in bursts, and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
`default_nettype none

module best_fit_segment_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR = bfsa_pkg::HEADER_BYTES_DEF;
  localparam int SETTLE_CYCLES = 2 * bfsa_pkg::MAX_SEGMENTS_DEF + 12;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [20:0] arena_bytes;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [19:0] alloc_bytes;
  logic [19:0] release_offset;
  logic        done;
  logic        granted;
  logic [19:0] payload_offset;
  logic [2:0]  error_code;
  int          fail_count;
  int          pending;

  logic [19:0] live_offsets[$];
  int          burst_left;

  best_fit_segment_allocator DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .arena_bytes(arena_bytes),
    .start(start), .busy(busy), .req_type(req_type), .alloc_bytes(alloc_bytes),
    .release_offset(release_offset), .done(done), .granted(granted),
    .payload_offset(payload_offset), .error_code(error_code)
  );

  best_fit_segment_allocator_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .arena_bytes(arena_bytes),
    .start(start), .busy(busy), .req_type(req_type), .alloc_bytes(alloc_bytes),
    .release_offset(release_offset), .done(done), .granted(granted),
    .payload_offset(payload_offset), .error_code(error_code),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done && granted && payload_offset != 0) live_offsets.push_back(payload_offset);
  end

  task automatic send_request(logic rt, logic [19:0] want, logic [19:0] off);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start          <= 1'b1;
    req_type       <= rt;
    alloc_bytes    <= want;
    release_offset <= off;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_all();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_arena(logic [20:0] value);
    drain_all();
    cfg_we      <= 1'b1;
    arena_bytes <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_offsets.delete();
  endtask

  task automatic random_requests(int count, int max_want);
    int          idx;
    logic [19:0] off;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 19) == 0) send_request(bfsa_pkg::REQ_ALLOC, 20'($urandom()), '0);
        else send_request(bfsa_pkg::REQ_ALLOC, 20'($urandom_range(0, max_want)),
                          20'($urandom()));
      end else if (live_offsets.size() != 0 && $urandom_range(0, 9) < 8) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        off = live_offsets[idx];
        if ($urandom_range(0, 9) != 0) live_offsets.delete(idx);
        send_request(bfsa_pkg::REQ_RELEASE, 20'($urandom()), off);
      end else begin
        send_request(bfsa_pkg::REQ_RELEASE, 20'($urandom_range(0, max_want)),
                     20'($urandom()));
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    arena_bytes    = '0;
    start          = 1'b0;
    req_type       = bfsa_pkg::REQ_ALLOC;
    alloc_bytes    = '0;
    release_offset = '0;
    burst_left     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(bfsa_pkg::REQ_ALLOC, 20'd100, '0);
    send_request(bfsa_pkg::REQ_ALLOC, 20'd0, '0);
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'hFFFFF);
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'(HDR));
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'(2 * HDR + 100));
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'(2 * HDR + 100));
    send_request(bfsa_pkg::REQ_ALLOC, 20'hFFFFF, '0);
    send_request(bfsa_pkg::REQ_ALLOC, 20'(1048576 - HDR), '0);
    send_request(bfsa_pkg::REQ_ALLOC, 20'd1, '0);
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'(HDR));
    send_request(bfsa_pkg::REQ_ALLOC, 20'(1048576 - 2 * HDR + 1), '0);
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'(HDR));

    write_arena(21'd0);
    send_request(bfsa_pkg::REQ_ALLOC, 20'd0, '0);
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'(HDR));
    write_arena(21'(HDR - 1));
    send_request(bfsa_pkg::REQ_ALLOC, 20'd0, '0);
    write_arena(21'(HDR));
    send_request(bfsa_pkg::REQ_ALLOC, 20'd1, '0);
    send_request(bfsa_pkg::REQ_ALLOC, 20'd0, '0);
    send_request(bfsa_pkg::REQ_RELEASE, '0, 20'(HDR));
    write_arena(21'(HDR + 1));
    send_request(bfsa_pkg::REQ_ALLOC, 20'd0, '0);

    write_arena(21'h1FFFFF);
    random_requests(250, 300);
    write_arena(21'd5000);
    random_requests(200, 200);
    write_arena(21'h100000);
    random_requests(250, 2000);
    write_arena(21'($urandom_range(HDR, 21'h1FFFFF)));
    random_requests(150, 60000);
    write_arena(21'($urandom_range(HDR, 3000)));
    random_requests(180, 100);

    drain_all();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/bfsa_pkg.sv
rtl/core/best_fit_segment_allocator.sv
rtl/core/bfsa_checker.sv
dv/best_fit_segment_allocator_checker.sv
dv/best_fit_segment_allocator_test.sv
